/* sv/pal_pkg.sv */
// ----------------------------------------------------------------------------
// pal_pkg
// Shared types, codes and the control store of the positional array list.
// ----------------------------------------------------------------------------
package pal_pkg;

   localparam int CAPACITY_DEF     = 32;
   localparam int ELEMENT_BITS_DEF = 32;
   localparam int VALUE_BITS       = 32;
   localparam int POS_BITS         = 6;
   localparam int LEN_BITS         = 6;

   typedef enum logic [2:0] {
      ACT_CLEAR  = 3'd0,
      ACT_GET    = 3'd1,
      ACT_PRIOR  = 3'd2,
      ACT_NEXT   = 3'd3,
      ACT_INSERT = 3'd4,
      ACT_DELETE = 3'd5
   } action_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_BADPOS   = 2'd1,
      ST_NOTFOUND = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   typedef struct packed {
      logic [2:0]            action;
      logic [POS_BITS-1:0]   position;
      logic [VALUE_BITS-1:0] item_value;
   } pal_req_type;

   typedef struct packed {
      logic [1:0]            status;
      logic [VALUE_BITS-1:0] read_value;
      logic [LEN_BITS-1:0]   list_length;
      logic                  is_empty;
   } pal_rsp_type;

   typedef enum logic [4:0] {
      S_FETCH, S_DECODE, S_CLR,
      S_GET0, S_GET1,
      S_DEL0, S_DEL1, S_DEL2, S_DEL3, S_DEL4,
      S_INS0, S_INS1, S_INS2, S_INS3, S_INS4,
      S_SCN0, S_SCN1, S_SCN2,
      S_EMIT
   } step_type;

   typedef enum logic [3:0] {
      D_NONE, D_CLEAR, D_RDPOS, D_TAKE, D_SHIFT, D_FLUSH, D_DEC,
      D_INSCHK, D_PUT, D_SCANINIT, D_SCAN, D_SCANEND, D_EMIT
   } dop_type;

   typedef enum logic [1:0] {
      H_NONE, H_ALWAYS, H_MORE_UP, H_MORE_DN
   } hold_type;

   typedef enum logic [3:0] {
      C_NEVER, C_ALWAYS, C_REQ, C_OUTFREE, C_DISPATCH, C_BAD_RD,
      C_INS_REJECT, C_POS_GT_N, C_IDX_GE_N, C_N_LT2, C_HIT
   } cond_type;

   typedef struct packed {
      dop_type  dop;
      hold_type hold;
      cond_type cond;
      step_type target;
   } ucode_type;

   function automatic ucode_type ucode_rom(step_type s);
      ucode_type w;
      case (s)
         S_FETCH:  w = '{D_NONE,     H_ALWAYS,  C_REQ,        S_DECODE};
         S_DECODE: w = '{D_NONE,     H_NONE,    C_DISPATCH,   S_EMIT};
         S_CLR:    w = '{D_CLEAR,    H_NONE,    C_ALWAYS,     S_EMIT};
         S_GET0:   w = '{D_RDPOS,    H_NONE,    C_BAD_RD,     S_EMIT};
         S_GET1:   w = '{D_TAKE,     H_NONE,    C_ALWAYS,     S_EMIT};
         S_DEL0:   w = '{D_RDPOS,    H_NONE,    C_BAD_RD,     S_EMIT};
         S_DEL1:   w = '{D_TAKE,     H_NONE,    C_IDX_GE_N,   S_DEL4};
         S_DEL2:   w = '{D_SHIFT,    H_MORE_UP, C_NEVER,      S_FETCH};
         S_DEL3:   w = '{D_FLUSH,    H_NONE,    C_NEVER,      S_FETCH};
         S_DEL4:   w = '{D_DEC,      H_NONE,    C_ALWAYS,     S_EMIT};
         S_INS0:   w = '{D_INSCHK,   H_NONE,    C_INS_REJECT, S_EMIT};
         S_INS1:   w = '{D_NONE,     H_NONE,    C_POS_GT_N,   S_INS4};
         S_INS2:   w = '{D_SHIFT,    H_MORE_DN, C_NEVER,      S_FETCH};
         S_INS3:   w = '{D_FLUSH,    H_NONE,    C_NEVER,      S_FETCH};
         S_INS4:   w = '{D_PUT,      H_NONE,    C_ALWAYS,     S_EMIT};
         S_SCN0:   w = '{D_SCANINIT, H_NONE,    C_N_LT2,      S_EMIT};
         S_SCN1:   w = '{D_SCAN,     H_MORE_UP, C_HIT,        S_EMIT};
         S_SCN2:   w = '{D_SCANEND,  H_NONE,    C_ALWAYS,     S_EMIT};
         S_EMIT:   w = '{D_EMIT,     H_ALWAYS,  C_OUTFREE,    S_FETCH};
         default:  w = '{D_NONE,     H_NONE,    C_ALWAYS,     S_FETCH};
      endcase
      return w;
   endfunction

   function automatic step_type entry_step(action_type a);
      step_type s;
      case (a)
         ACT_CLEAR:  s = S_CLR;
         ACT_GET:    s = S_GET0;
         ACT_PRIOR:  s = S_SCN0;
         ACT_NEXT:   s = S_SCN0;
         ACT_INSERT: s = S_INS0;
         ACT_DELETE: s = S_DEL0;
         default:    s = S_EMIT;
      endcase
      return s;
   endfunction

endpackage

/* sv/positional_array_list_core.sv */
// ----------------------------------------------------------------------------
// positional_array_list_core
// Fixed-capacity ordered list in a one-read, one-write store, driven by a
// microcoded sequencer that walks the store one entry per cycle.
// ----------------------------------------------------------------------------
//  Channel  Direction  Payload        Handshake
//  req      in         pal_req_type   req_valid / req_stall
//  rsp      out        pal_rsp_type   rsp_valid / rsp_stall
//
// Fetch and decode open each item and posting the result closes it; an unused
// code or a refused item goes straight to posting. Insert and delete walk the
// tail only when it moves, prior and next scan the list until a match, and
// the single read port of the store sets these walks.
// Reset clears the sequencer, the result valid, the length count and the
// pending-write flag only. A held result sits in the output register while
// the next item is taken.
module positional_array_list_core #(
   parameter int CAPACITY     = pal_pkg::CAPACITY_DEF,
   parameter int ELEMENT_BITS = pal_pkg::ELEMENT_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  pal_pkg::pal_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output pal_pkg::pal_rsp_type rsp_data
);
   import pal_pkg::*;

   localparam int IW = $clog2(CAPACITY + 1);
   localparam int AW = $clog2(CAPACITY);
   localparam int CW = ((IW > POS_BITS) ? IW : POS_BITS) + 1;

   logic [ELEMENT_BITS-1:0] mem [CAPACITY];

   step_type                upc_ff, upc_in;
   action_type              act_ff, act_in;
   logic [POS_BITS-1:0]     pos_ff, pos_in;
   logic [ELEMENT_BITS-1:0] val_ff, val_in;
   logic [IW-1:0]           count_ff, count_in;
   logic [IW-1:0]           idx_ff, idx_in;
   logic [AW-1:0]           tag_ff, tag_in;
   logic                    pend_ff, pend_in;
   status_type              status_ff, status_in;
   logic [ELEMENT_BITS-1:0] rd_ff, rd_in;
   logic [ELEMENT_BITS-1:0] rdata_ff;
   logic [ELEMENT_BITS-1:0] prev_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   pal_rsp_type             rsp_ff, rsp_in;

   ucode_type               uc;
   step_type                tgt;
   logic                    cond_true, hold_true;
   logic                    req_accept, out_free;
   logic [CW-1:0]           pos_x, n_x, idx_x;
   logic                    bad_rd, bad_ins, full, hit, is_prior, walk_dn;
   logic [POS_BITS-1:0]     pos_m1;
   logic                    mem_we;
   logic [AW-1:0]           mem_waddr, mem_raddr;
   logic [ELEMENT_BITS-1:0] mem_wdata;

   assign uc         = ucode_rom(upc_ff);
   assign req_stall  = reset || (upc_ff != S_FETCH);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   assign pos_x    = CW'(pos_ff);
   assign n_x      = CW'(count_ff);
   assign idx_x    = CW'(idx_ff);
   assign pos_m1   = pos_ff - POS_BITS'(1);
   assign bad_rd   = (pos_ff == '0) || (pos_x > n_x);
   assign bad_ins  = (pos_ff == '0) || (pos_x > (n_x + CW'(1)));
   assign full     = n_x >= CW'(CAPACITY);
   assign is_prior = act_ff == ACT_PRIOR;
   assign walk_dn  = act_ff == ACT_INSERT;
   assign hit      = pend_ff && (tag_ff != '0)
                     && (is_prior ? (rdata_ff == val_ff) : (prev_ff == val_ff));

   always_comb begin
      case (uc.cond)
         C_NEVER:      cond_true = 1'b0;
         C_ALWAYS:     cond_true = 1'b1;
         C_REQ:        cond_true = req_accept;
         C_OUTFREE:    cond_true = out_free;
         C_DISPATCH:   cond_true = 1'b1;
         C_BAD_RD:     cond_true = bad_rd;
         C_INS_REJECT: cond_true = bad_ins || full;
         C_POS_GT_N:   cond_true = pos_x > n_x;
         C_IDX_GE_N:   cond_true = idx_ff >= count_ff;
         C_N_LT2:      cond_true = n_x < CW'(2);
         C_HIT:        cond_true = hit;
         default:      cond_true = 1'b0;
      endcase
      case (uc.hold)
         H_NONE:    hold_true = 1'b0;
         H_ALWAYS:  hold_true = 1'b1;
         H_MORE_UP: hold_true = (idx_x + CW'(1)) < n_x;
         H_MORE_DN: hold_true = idx_x >= pos_x;
         default:   hold_true = 1'b0;
      endcase
      tgt = (uc.cond == C_DISPATCH) ? entry_step(act_ff) : uc.target;
      if (cond_true) begin
         upc_in = tgt;
      end else if (hold_true) begin
         upc_in = upc_ff;
      end else begin
         upc_in = step_type'(upc_ff + 5'd1);
      end

      act_in       = act_ff;
      pos_in       = pos_ff;
      val_in       = val_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      tag_in       = tag_ff;
      pend_in      = pend_ff;
      status_in    = status_ff;
      rd_in        = rd_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mem_we       = 1'b0;
      mem_waddr    = walk_dn ? (tag_ff + AW'(1)) : (tag_ff - AW'(1));
      mem_wdata    = rdata_ff;
      mem_raddr    = idx_ff[AW-1:0];

      if (req_accept) begin
         act_in    = action_type'(req_data.action);
         pos_in    = req_data.position;
         val_in    = ELEMENT_BITS'(req_data.item_value);
         status_in = ST_OK;
         rd_in     = '0;
         pend_in   = 1'b0;
      end

      case (uc.dop)
         D_NONE: begin
         end
         D_CLEAR: begin
            count_in = '0;
         end
         D_RDPOS: begin
            mem_raddr = pos_m1[AW-1:0];
            idx_in    = IW'(pos_ff);
            status_in = bad_rd ? ST_BADPOS : ST_OK;
         end
         D_TAKE: begin
            rd_in = rdata_ff;
         end
         D_SHIFT: begin
            mem_we  = pend_ff;
            tag_in  = idx_ff[AW-1:0];
            pend_in = 1'b1;
            idx_in  = walk_dn ? (idx_ff - IW'(1)) : (idx_ff + IW'(1));
         end
         D_FLUSH: begin
            mem_we  = pend_ff;
            pend_in = 1'b0;
         end
         D_DEC: begin
            count_in = count_ff - IW'(1);
         end
         D_INSCHK: begin
            status_in = bad_ins ? ST_BADPOS : (full ? ST_FULL : ST_OK);
            idx_in    = count_ff - IW'(1);
         end
         D_PUT: begin
            mem_we    = 1'b1;
            mem_waddr = pos_m1[AW-1:0];
            mem_wdata = val_ff;
            count_in  = count_ff + IW'(1);
         end
         D_SCANINIT: begin
            status_in = ST_NOTFOUND;
            idx_in    = '0;
         end
         D_SCAN: begin
            tag_in  = idx_ff[AW-1:0];
            pend_in = 1'b1;
            idx_in  = idx_ff + IW'(1);
            if (hit) begin
               status_in = ST_OK;
               rd_in     = is_prior ? prev_ff : rdata_ff;
            end
         end
         D_SCANEND: begin
            pend_in = 1'b0;
            if (hit) begin
               status_in = ST_OK;
               rd_in     = is_prior ? prev_ff : rdata_ff;
            end
         end
         D_EMIT: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.status      = status_ff;
               rsp_in.read_value  = VALUE_BITS'(rd_ff);
               rsp_in.list_length = LEN_BITS'(count_ff);
               rsp_in.is_empty    = count_ff == '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff       <= S_FETCH;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         upc_ff       <= upc_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff    <= act_in;
      pos_ff    <= pos_in;
      val_ff    <= val_in;
      idx_ff    <= idx_in;
      tag_ff    <= tag_in;
      status_ff <= status_in;
      rd_ff     <= rd_in;
      rsp_ff    <= rsp_in;
      prev_ff   <= rdata_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_raddr];
   end

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      n_x <= CW'(CAPACITY))
      else $error("list length above capacity");

   a_accept_decode : assert property (@(posedge clock) disable iff (reset)
      req_accept |=> upc_ff == S_DECODE)
      else $error("accepted item not decoded");

   a_emit_done : assert property (@(posedge clock) disable iff (reset)
      (uc.dop == D_EMIT) && out_free |=> (upc_ff == S_FETCH) && rsp_valid_ff)
      else $error("result not posted on emit");

   a_write_range : assert property (@(posedge clock) disable iff (reset)
      mem_we |-> CW'(mem_waddr) < CW'(CAPACITY))
      else $error("store write outside capacity");

endmodule
